### rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants for the 12-bit LZW compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

	localparam int DEF_MAX_CODES = 4096;
	localparam int DEF_CODE_BITS = 12;
	localparam int BYTE_W        = 8;
	localparam int FIRST_FREE    = 256;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_FIN
	} lzwc_st_t;

endpackage

`default_nettype wire

### rtl/lzwc_dict.sv
// ----------------------------------------------------------------------------
// lzwc_dict
// Hash table memory for the dictionary: one write port, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_dict
	import lzwc_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int EW    = 33
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [EW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [EW-1:0] rdata
);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/lzw_compressor_12bit_unit.sv
// ----------------------------------------------------------------------------
// lzw_compressor_12bit_unit
// LZW compressor: bytes in, codes out, hashed dictionary with linear probing.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata = data_byte, tlast = is_last
//  m_axis    out  m_axis_tvalid/tready    tdata = code, tlast = end_of_stream
//
//  A byte at the start of a stream goes IDLE then FIN; any other byte probes
//  the hash table: each probe is one registered read (RD) and a compare (CMP).
//  A miss or the last byte may wait for the output register to free up.
//  After reset and after every last byte a sweep clears the table, one entry
//  a cycle, all 2**clog2(MAX_CODES) entries; s_axis_tready stays low meanwhile.
//  Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_compressor_12bit_unit
	import lzwc_pkg::*;
#(
	parameter int MAX_CODES = DEF_MAX_CODES,
	parameter int CODE_BITS = DEF_CODE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [((CODE_BITS+7)/8)*8-1:0] m_axis_tdata, // [CODE_BITS-1:0] code
	output logic                       m_axis_tlast
);

	localparam int AW    = $clog2(MAX_CODES);
	localparam int DEPTH = 2 ** AW;
	localparam int NW    = $clog2(MAX_CODES + 1);
	localparam int EW    = 1 + CODE_BITS + BYTE_W + CODE_BITS;
	localparam int OW    = ((CODE_BITS + 7) / 8) * 8;

	lzwc_st_t state_q, state_d;

	logic [BYTE_W-1:0]    ch_q;
	logic                 last_q;
	logic [CODE_BITS-1:0] pfx_q;
	logic                 pv_q;
	logic [NW-1:0]        nfc_q;
	logic [AW-1:0]        probe_q;
	logic [AW-1:0]        clr_q;
	logic                 out_v_q;
	logic [CODE_BITS-1:0] code_q;
	logic                 eos_q;

	logic [EW-1:0]        rdata;
	logic                 e_v;
	logic [CODE_BITS-1:0] e_pfx;
	logic [BYTE_W-1:0]    e_ch;
	logic [CODE_BITS-1:0] e_code;
	logic                 hit;
	logic                 out_free;
	logic                 accept;
	logic                 clr_done;

	logic                 emit;
	logic [CODE_BITS-1:0] emit_code;
	logic                 emit_eos;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [EW-1:0]        mem_wdata;
	logic                 room;

	assign {e_v, e_pfx, e_ch, e_code} = rdata;
	assign hit      = e_v && (e_pfx == pfx_q) && (e_ch == ch_q);
	assign out_free = !out_v_q || m_axis_tready;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign clr_done = (clr_q == {AW{1'b1}});
	assign room     = (nfc_q < NW'(MAX_CODES));

	lzwc_dict #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.EW   (EW)
	) u_dict (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(probe_q),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = pv_q ? ST_RD : ST_FIN;
			end
			ST_RD:    state_d = ST_CMP;
			ST_CMP: begin
				if (hit) state_d = ST_FIN;
				else if (e_v) state_d = ST_RD;
				else if (out_free) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!last_q) state_d = ST_IDLE;
				else if (out_free) state_d = ST_CLEAR;
			end
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		emit          = 1'b0;
		emit_code     = pfx_q;
		emit_eos      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = probe_q;
		mem_wdata     = {1'b1, pfx_q, ch_q, CODE_BITS'(nfc_q)};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_RD:    ;
			ST_CMP: begin
				if (!e_v && out_free) begin
					emit   = 1'b1;
					mem_we = room;
				end
			end
			ST_FIN: begin
				if (last_q && out_free) begin
					emit     = 1'b1;
					emit_eos = 1'b1;
				end
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pv_q    <= 1'b0;
			pfx_q   <= '0;
			nfc_q   <= NW'(FIRST_FREE);
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept && !pv_q) begin
				pv_q  <= 1'b1;
				pfx_q <= CODE_BITS'(s_axis_tdata);
			end
			if (state_q == ST_CMP && hit) pfx_q <= e_code;
			if (state_q == ST_CMP && emit) begin
				pfx_q <= CODE_BITS'(ch_q);
				if (room) nfc_q <= nfc_q + 1'b1;
			end
			if (state_q == ST_FIN && emit) begin
				pv_q  <= 1'b0;
				pfx_q <= '0;
				nfc_q <= NW'(FIRST_FREE);
			end
			if (emit) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= s_axis_tdata;
			last_q <= s_axis_tlast;
			// hash of (prefix, byte)
			probe_q <= AW'(pfx_q) ^ (AW'(s_axis_tdata) << (AW - BYTE_W));
		end else if (state_q == ST_CMP && !hit && e_v) begin
			probe_q <= probe_q + 1'b1;
		end
		if (emit) begin
			code_q <= emit_code;
			eos_q  <= emit_eos;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OW'(code_q);
	assign m_axis_tlast  = eos_q;

endmodule

`default_nettype wire

### rtl/lzwc_checker.sv
// ----------------------------------------------------------------------------
// lzwc_checker
// Port-level checks for the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_checker
	import lzwc_pkg::*;
#(
	parameter int OW = 16
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_axis_tvalid,
	input wire logic          s_axis_tready,
	input wire logic          m_axis_tvalid,
	input wire logic          m_axis_tready,
	input wire logic [OW-1:0] m_axis_tdata,
	input wire logic          m_axis_tlast
);

	// one byte at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after accept");

	// final code starts the table sweep
	a_sweep_after_eos: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_axis_tvalid) && m_axis_tlast) |=> !s_axis_tready)
		else $error("input ready during table sweep");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output item changed while stalled");

endmodule

bind lzw_compressor_12bit_unit lzwc_checker #(
	.OW(((CODE_BITS + 7) / 8) * 8)
) u_lzwc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

### tb/tb_lzw_compressor_12bit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzw_compressor_12bit_unit
// Drives byte streams into the LZW compressor and checks every emitted code
// and its end marker against a behavioral LZW coder kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lzw_compressor_12bit_unit;
	import lzwc_pkg::*;

	localparam int NCODES = DEF_MAX_CODES;
	localparam int CBITS  = DEF_CODE_BITS;
	localparam int TDW    = ((CBITS + 7) / 8) * 8;
	localparam int NDIR   = 14;
	localparam int NRAND  = 1400;
	localparam int NLONG  = 300;
	localparam logic [CBITS-1:0] NO_CODE = '1;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             is_last;
		logic [CBITS-1:0] code0;  // typed-in expectations, NO_CODE where predicted
		logic [CBITS-1:0] code1;
	} byte_row_t;

	typedef struct packed {
		logic [CBITS-1:0] code;
		logic             eos;
	} lzw_code_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDW-1:0] m_axis_tdata;
	logic m_axis_tlast;

	lzw_compressor_12bit_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// coder state
	logic [CBITS-1:0] dict_pfx [NCODES];
	logic [7:0]       dict_chr [NCODES];
	int               free_code;
	logic [CBITS-1:0] cur_prefix;
	bit               have_prefix;

	lzw_code_t pending_codes[$];
	int        n_fail = 0;
	bit        no_idle = 1'b0;
	int        row_base = 0;  // queue index of the first code predicted for the last byte

	byte_row_t dir_rows [NDIR] = '{
		'{8'h00, 1'b1, 12'd0,   NO_CODE},  // single-byte stream
		'{8'hFF, 1'b1, 12'd255, NO_CODE},
		'{8'h41, 1'b0, NO_CODE, NO_CODE},
		'{8'h41, 1'b0, 12'd65,  NO_CODE},  // learns 256 = AA
		'{8'h41, 1'b0, NO_CODE, NO_CODE},  // hit on 256
		'{8'h41, 1'b1, 12'd256, 12'd65},   // miss on the last byte: two codes
		'{8'h00, 1'b0, NO_CODE, NO_CODE},
		'{8'hFF, 1'b0, 12'd0,   NO_CODE},
		'{8'h00, 1'b0, 12'd255, NO_CODE},
		'{8'hFF, 1'b0, NO_CODE, NO_CODE},
		'{8'h00, 1'b0, 12'd256, NO_CODE},
		'{8'hFF, 1'b0, NO_CODE, NO_CODE},
		'{8'h00, 1'b0, NO_CODE, NO_CODE},
		'{8'h55, 1'b1, NO_CODE, NO_CODE}
	};

	function automatic void clear_dict();
		free_code   = FIRST_FREE;
		cur_prefix  = '0;
		have_prefix = 1'b0;
	endfunction

	function automatic void predict_codes(input logic [7:0] b, input logic last);
		int hit;
		hit = -1;
		if (!have_prefix) begin
			cur_prefix  = CBITS'(b);
			have_prefix = 1'b1;
		end else begin
			for (int k = FIRST_FREE; k < free_code; k++)
				if (dict_pfx[k] == cur_prefix && dict_chr[k] == b) begin
					hit = k;
					break;
				end
			if (hit >= 0)
				cur_prefix = CBITS'(hit);
			else begin
				pending_codes.push_back('{cur_prefix, 1'b0});
				if (free_code < NCODES) begin
					dict_pfx[free_code] = cur_prefix;
					dict_chr[free_code] = b;
					free_code++;
				end
				cur_prefix = CBITS'(b);
			end
		end
		if (last) begin
			pending_codes.push_back('{cur_prefix, 1'b1});
			clear_dict();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!no_idle && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		row_base = pending_codes.size();
		predict_codes(b, last);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("status: fail");
		$finish;
	end

	// sink: random stall, compare each accepted code with the oldest expectation
	always @(posedge clk) begin
		lzw_code_t want;
		m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_codes.size() == 0) begin
				$error("unexpected code %0d", m_axis_tdata[CBITS-1:0]);
				n_fail++;
			end else begin
				want = pending_codes.pop_front();
				if (m_axis_tdata[CBITS-1:0] !== want.code) begin
					$error("code: expected %0d, actual %0d", want.code,
						m_axis_tdata[CBITS-1:0]);
					n_fail++;
				end
				if (m_axis_tlast !== want.eos) begin
					$error("end_of_stream: expected %0d, actual %0d", want.eos,
						m_axis_tlast);
					n_fail++;
				end
			end
		end
	end

	initial begin
		int n_sent, run_len, mode, wait_cyc;
		logic [7:0] b;
		logic [7:0] alpha [4];
		clear_dict();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].data_byte, dir_rows[i].is_last);
			if (dir_rows[i].code0 != NO_CODE &&
					pending_codes[row_base].code != dir_rows[i].code0) begin
				$error("code: expected %0d, actual %0d", dir_rows[i].code0,
					pending_codes[row_base].code);
				n_fail++;
			end
			if (dir_rows[i].code1 != NO_CODE &&
					pending_codes[row_base+1].code != dir_rows[i].code1) begin
				$error("code: expected %0d, actual %0d", dir_rows[i].code1,
					pending_codes[row_base+1].code);
				n_fail++;
			end
		end

		// random streams: mostly short, small alphabets so the dictionary gets hits
		n_sent = 0;
		while (n_sent < NRAND) begin
			run_len = (n_sent > NRAND - 200) ? $urandom_range(1, 40) : $urandom_range(1, 120);
			mode = $urandom_range(3);
			no_idle = (n_sent > 600 && n_sent < 900);
			foreach (alpha[j]) alpha[j] = 8'($urandom);
			for (int j = 0; j < run_len; j++) begin
				b = (mode == 0) ? 8'($urandom) : alpha[$urandom_range(mode)];
				send_byte(b, j == run_len - 1);
				n_sent++;
			end
		end

		// one longer stream of random bytes for a deeper dictionary
		for (int j = 0; j < NLONG; j++)
			send_byte(8'($urandom), j == NLONG - 1);

		s_axis_tvalid <= 1'b0;
		wait_cyc = 0;
		while (pending_codes.size() != 0 && wait_cyc < 200000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (50) @(posedge clk);
		if (n_fail == 0 && pending_codes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/lzwc_pkg.sv
rtl/lzwc_dict.sv
rtl/lzw_compressor_12bit_unit.sv
rtl/lzwc_checker.sv
tb/tb_lzw_compressor_12bit_unit.sv
